FILE: rtl/psp_pkg.sv
// psp_pkg: shared types and constants for the polytope symbol parser.
// Holds status codes, character codes, pattern flag bits and the result word type.
// No dependencies.
package psp_pkg;

   localparam int MAX_COMPONENTS_DEF = 16;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_OPEN  = 3'd1;
   localparam logic [2:0] ST_BAD_CHAR = 3'd2;
   localparam logic [2:0] ST_NO_CLOSE = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_OPEN  = 8'h7B;
   localparam logic [7:0] CH_CLOSE = 8'h7D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // pattern flag bit positions
   localparam int FL_GE3   = 0;
   localparam int FL_ALL3  = 1;
   localparam int FL_TAIL3 = 2;
   localparam int FL_CROSS = 3;
   localparam int FL_W     = 4;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  component_count;
      logic [4:0]  dimension;
      logic        known_regular;
      logic [31:0] first_value;
      logic [31:0] second_value;
      logic [31:0] third_value;
   } result_type;

endpackage

FILE: rtl/psp_classify.sv
// psp_classify: regular polytope test on the stored components and flags.
// Purely combinational; uses psp_pkg for flag positions.
module psp_classify #(
   parameter int CW = 5
) (
   input  logic [CW-1:0]           count,
   input  logic [psp_pkg::FL_W-1:0] flags,
   input  logic [31:0]             p,
   input  logic [31:0]             q,
   input  logic [31:0]             r,
   output logic                    regular
);
   import psp_pkg::*;

   logic p3, p4, p5, q3, q4, q5, r3, r4, r5;
   logic two_ok, three_ok, long_ok;

   always_comb begin
      p3 = (p == 32'd3);
      p4 = (p == 32'd4);
      p5 = (p == 32'd5);
      q3 = (q == 32'd3);
      q4 = (q == 32'd4);
      q5 = (q == 32'd5);
      r3 = (r == 32'd3);
      r4 = (r == 32'd4);
      r5 = (r == 32'd5);
      two_ok   = (p3 && q3) || (p4 && q3) || (p3 && q4) || (p5 && q3) || (p3 && q5);
      three_ok = (p3 && q3 && r3) || (p4 && q3 && r3) || (p3 && q3 && r4) ||
                 (p3 && q4 && r3) || (p5 && q3 && r3) || (p3 && q3 && r5);
      long_ok  = flags[FL_ALL3] || (p4 && flags[FL_TAIL3]) || flags[FL_CROSS];
      regular  = 1'b0;
      if (flags[FL_GE3]) begin
         if (count == CW'(2))
            regular = two_ok;
         else if (count == CW'(3))
            regular = three_ok;
         else if (count >= CW'(4))
            regular = long_ok;
      end
   end

endmodule

FILE: rtl/psp_parser.sv
// psp_parser: per-character parse state machine and component store.
// Produces one result word when a string is decided; uses psp_pkg and psp_classify.
module psp_parser #(
   parameter int MAX_COMPONENTS = psp_pkg::MAX_COMPONENTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          char_code,
   output logic                emit,
   output psp_pkg::result_type result
);
   import psp_pkg::*;

   localparam int CW = $clog2(MAX_COMPONENTS + 1);

   localparam logic [2:0] PH_OPEN = 3'd0;
   localparam logic [2:0] PH_TOP  = 3'd1;
   localparam logic [2:0] PH_BODY = 3'd2;
   localparam logic [2:0] PH_NUM  = 3'd3;
   localparam logic [2:0] PH_TAIL = 3'd4;
   localparam logic [2:0] PH_SKIP = 3'd5;

   logic [2:0]      phase_ff, phase_in;
   logic [31:0]     acc_ff, acc_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [31:0]     p_ff, p_in, q_ff, q_in, r_ff, r_in;
   logic [FL_W-1:0] flags_ff, flags_in;

   logic            is_ws, is_dig;
   logic [31:0]     digit;
   logic [CW-1:0]   st_count, v_count;
   logic [31:0]     st_p, st_q, st_r, v_p, v_q, v_r;
   logic [FL_W-1:0] st_flags, v_flags;
   logic            use_store, finish, commit, regular;
   logic [2:0]      status;
   logic [31:0]     cnt32;

   psp_classify #(.CW(CW)) u_classify (
      .count   (v_count),
      .flags   (v_flags),
      .p       (v_p),
      .q       (v_q),
      .r       (v_r),
      .regular (regular)
   );

   always_comb begin
      is_ws  = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
      is_dig = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
      digit  = 32'(char_code - CH_ZERO) & 32'h0000_000F;

      // component store as taken at the end of a number
      st_count = count_ff + CW'(1);
      st_p = (count_ff == CW'(0)) ? acc_ff : p_ff;
      st_q = (count_ff == CW'(1)) ? acc_ff : q_ff;
      st_r = (count_ff == CW'(2)) ? acc_ff : r_ff;
      st_flags = '0;
      st_flags[FL_GE3]   = flags_ff[FL_GE3] && (acc_ff >= 32'd3);
      st_flags[FL_CROSS] = flags_ff[FL_ALL3] && (acc_ff == 32'd4);
      st_flags[FL_ALL3]  = flags_ff[FL_ALL3] && (acc_ff == 32'd3);
      st_flags[FL_TAIL3] = (count_ff == CW'(0)) || (flags_ff[FL_TAIL3] && (acc_ff == 32'd3));

      use_store = (phase_ff == PH_NUM);
      v_count = use_store ? st_count : count_ff;
      v_p     = use_store ? st_p     : p_ff;
      v_q     = use_store ? st_q     : q_ff;
      v_r     = use_store ? st_r     : r_ff;
      v_flags = use_store ? st_flags : flags_ff;

      phase_in = phase_ff;
      acc_in   = acc_ff;
      finish   = 1'b0;
      commit   = 1'b0;
      status   = ST_OK;

      unique case (phase_ff)
         PH_OPEN: begin
            if (char_code == CH_OPEN) begin
               phase_in = PH_TOP;
            end else if (!is_ws) begin
               finish = 1'b1;
               status = ST_NO_OPEN;
            end
         end
         PH_TOP, PH_BODY, PH_TAIL: begin
            if (phase_ff == PH_TOP && count_ff >= CW'(MAX_COMPONENTS)) begin
               finish = 1'b1;
               if (char_code == CH_CLOSE)
                  status = (count_ff == CW'(0)) ? ST_EMPTY : ST_OK;
               else
                  status = ST_NO_CLOSE;
            end else if (phase_ff != PH_TAIL && is_dig) begin
               acc_in   = digit;
               phase_in = PH_NUM;
            end else if (is_ws) begin
               phase_in = (phase_ff == PH_TAIL) ? PH_TAIL : PH_BODY;
            end else if (char_code == CH_COMMA) begin
               phase_in = PH_TOP;
            end else begin
               finish = 1'b1;
               if (char_code == CH_CLOSE)
                  status = (count_ff == CW'(0)) ? ST_EMPTY : ST_OK;
               else if (char_code == CH_NUL)
                  status = ST_NO_CLOSE;
               else
                  status = ST_BAD_CHAR;
            end
         end
         PH_NUM: begin
            if (is_dig) begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + digit;
            end else begin
               commit = 1'b1;
               acc_in = 32'd0;
               if (is_ws) begin
                  phase_in = PH_TAIL;
               end else if (char_code == CH_COMMA) begin
                  phase_in = PH_TOP;
               end else begin
                  finish = 1'b1;
                  if (char_code == CH_CLOSE)
                     status = ST_OK;
                  else if (char_code == CH_NUL)
                     status = ST_NO_CLOSE;
                  else
                     status = ST_BAD_CHAR;
               end
            end
         end
         PH_SKIP: begin
            if (char_code == CH_NUL)
               phase_in = PH_OPEN;
         end
         default: begin
            phase_in = PH_OPEN;
         end
      endcase

      count_in = commit ? st_count : count_ff;
      p_in     = commit ? st_p     : p_ff;
      q_in     = commit ? st_q     : q_ff;
      r_in     = commit ? st_r     : r_ff;
      flags_in = commit ? st_flags : flags_ff;

      if (finish) begin
         phase_in = (char_code == CH_NUL) ? PH_OPEN : PH_SKIP;
         acc_in   = 32'd0;
         count_in = '0;
         p_in     = 32'd0;
         q_in     = 32'd0;
         r_in     = 32'd0;
         flags_in = '1;
      end

      cnt32 = 32'(v_count);
      emit  = finish;
      result = '0;
      result.status = status;
      if (status == ST_OK) begin
         result.component_count = cnt32[4:0];
         result.dimension       = 5'(cnt32 + 32'd1);
         result.known_regular   = regular;
         result.first_value     = v_p;
         result.second_value    = v_q;
         result.third_value     = v_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPEN;
         acc_ff   <= 32'd0;
         count_ff <= '0;
         p_ff     <= 32'd0;
         q_ff     <= 32'd0;
         r_ff     <= 32'd0;
         flags_ff <= '1;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         p_ff     <= p_in;
         q_ff     <= q_in;
         r_ff     <= r_in;
         flags_ff <= flags_in;
      end
   end

endmodule

FILE: rtl/polytope_symbol_parse_classify.sv
// Polytope symbol parser and classifier: one character word per cycle.
// The result word is registered and is valid in the cycle after the deciding character is accepted.
// The parse state updates once for each accepted character.
// Input is held off only while the result register is full and stalled.
// Reset (synchronous, active high) returns the parser to waiting for '{' and
// empties the result register.
module polytope_symbol_parse_classify #(
   parameter int MAX_COMPONENTS = psp_pkg::MAX_COMPONENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_component_count,
   output logic [4:0]  rsp_dimension,
   output logic        rsp_known_regular,
   output logic [31:0] rsp_first_value,
   output logic [31:0] rsp_second_value,
   output logic [31:0] rsp_third_value
);
   import psp_pkg::*;

   logic       step, emit;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step      = req_valid && !req_stall;

   psp_parser #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (req_char_code),
      .emit      (emit),
      .result    (result)
   );

   always_comb begin
      if (step && emit)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (step && emit)
         rsp_ff <= result;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_component_count = rsp_ff.component_count;
   assign rsp_dimension       = rsp_ff.dimension;
   assign rsp_known_regular   = rsp_ff.known_regular;
   assign rsp_first_value     = rsp_ff.first_value;
   assign rsp_second_value    = rsp_ff.second_value;
   assign rsp_third_value     = rsp_ff.third_value;

endmodule

FILE: rtl/psp_checker.sv
// psp_checker: port-level assertions for the polytope symbol parser.
// Uses psp_pkg status codes; bound to the top level below.
module psp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [4:0]  rsp_component_count,
   input logic [4:0]  rsp_dimension,
   input logic        rsp_known_regular,
   input logic [31:0] rsp_first_value,
   input logic [31:0] rsp_second_value,
   input logic [31:0] rsp_third_value
);
   import psp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_first_value))
      else $error("stalled result word changed");

   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with result side free");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_component_count == 5'd0 &&
      rsp_dimension == 5'd0 && !rsp_known_regular && rsp_first_value == 32'd0 &&
      rsp_second_value == 32'd0 && rsp_third_value == 32'd0)
      else $error("failed result carries non-zero fields");

   a_dim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_dimension == 5'(rsp_component_count + 5'd1))
      else $error("dimension does not follow count");

   a_regular: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_known_regular |-> rsp_status == ST_OK &&
      rsp_first_value >= 32'd3 && rsp_second_value >= 32'd3)
      else $error("regular flag on invalid symbol");

endmodule

bind polytope_symbol_parse_classify psp_checker u_psp_checker (.*);
